[sv/apfc_pkg.sv]
// Shared types and constants of the address pair flow counter.
package apfc_pkg;

    localparam int ADDR_W  = 32;
    localparam int COUNT_W = 32;
    localparam int SLOT_W  = 6;
    localparam int USED_W  = 7;

    // Front queue geometry
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QLVL_W      = 2;

    typedef enum logic [0:0] {
        OP_RECORD = 1'b0,
        OP_READ   = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_FINISH
    } t_state;

    typedef struct packed {
        t_op                op;
        logic [ADDR_W-1:0]  src_addr;
        logic [ADDR_W-1:0]  dst_addr;
        logic [SLOT_W-1:0]  entry_index;
    } t_task;

    typedef struct packed {
        logic               hit;
        logic               inserted;
        logic               dropped_full;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] count;
        logic               entry_valid;
        logic [ADDR_W-1:0]  entry_src;
        logic [ADDR_W-1:0]  entry_dst;
        logic [USED_W-1:0]  entries_used;
    } t_result;

endpackage

[sv/apfc_if.sv]
// Valid/ready channel interfaces for the item and result streams.
interface apfc_item_if;
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic [apfc_pkg::ADDR_W-1:0] src_addr;
    logic [apfc_pkg::ADDR_W-1:0] dst_addr;
    logic [apfc_pkg::SLOT_W-1:0] entry_index;

    modport source (output valid, func, src_addr, dst_addr, entry_index, input ready);
    modport sink (input valid, func, src_addr, dst_addr, entry_index, output ready);
endinterface

interface apfc_result_if;
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic                         inserted;
    logic                         dropped_full;
    logic [apfc_pkg::SLOT_W-1:0]  slot;
    logic [apfc_pkg::COUNT_W-1:0] count;
    logic                         entry_valid;
    logic [apfc_pkg::ADDR_W-1:0]  entry_src;
    logic [apfc_pkg::ADDR_W-1:0]  entry_dst;
    logic [apfc_pkg::USED_W-1:0]  entries_used;

    modport source (output valid, hit, inserted, dropped_full, slot, count, entry_valid,
                    entry_src, entry_dst, entries_used, input ready);
    modport sink (input valid, hit, inserted, dropped_full, slot, count, entry_valid,
                  entry_src, entry_dst, entries_used, output ready);
endinterface

[sv/apfc_front.sv]
// Front end: accepts items, classifies them and queues them for the back end.
module apfc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    apfc_item_if.sink       i_item,
    output logic            o_q_valid,
    output apfc_pkg::t_task o_q_task,
    input  logic            i_q_ready
);

    apfc_pkg::t_task                 r_q [apfc_pkg::QUEUE_DEPTH];
    logic [apfc_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [apfc_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [apfc_pkg::QLVL_W-1:0]     r_level;
    logic                            push;
    logic                            pop;
    apfc_pkg::t_task                 in_task;

    always_comb begin
        in_task.op          = i_item.func ? apfc_pkg::OP_READ : apfc_pkg::OP_RECORD;
        in_task.src_addr    = i_item.src_addr;
        in_task.dst_addr    = i_item.dst_addr;
        in_task.entry_index = i_item.entry_index;
    end

    assign i_item.ready = (r_level != apfc_pkg::QLVL_W'(apfc_pkg::QUEUE_DEPTH));
    assign o_q_valid    = (r_level != '0);
    assign o_q_task     = r_q[r_rd_ptr];
    assign push         = i_item.valid && i_item.ready;
    assign pop          = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + apfc_pkg::QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + apfc_pkg::QPTR_W'(1);
            end
            if (push && !pop) begin
                r_level <= r_level + apfc_pkg::QLVL_W'(1);
            end else if (pop && !push) begin
                r_level <= r_level - apfc_pkg::QLVL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= in_task;
        end
    end

endmodule

[sv/apfc_back.sv]
// Back end: pair table memories, scan sequencer and result register.
module apfc_back #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  apfc_pkg::t_task i_q_task,
    output logic            o_q_ready,
    apfc_result_if.source   o_result
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > apfc_pkg::SLOT_W) ? CNT_W : apfc_pkg::SLOT_W;

    apfc_pkg::t_state              r_state;
    apfc_pkg::t_state              n_state;
    apfc_pkg::t_task               r_task;
    apfc_pkg::t_task               n_task;
    logic [IDX_W-1:0]              r_cmp_addr;
    logic [IDX_W-1:0]              n_cmp_addr;
    logic                          r_hit;
    logic                          n_hit;
    logic                          r_rd_ok;
    logic                          n_rd_ok;
    logic [CNT_W-1:0]              r_fill;
    logic [CNT_W-1:0]              n_fill;

    logic [apfc_pkg::ADDR_W-1:0]   mem_src [TABLE_ENTRIES];
    logic [apfc_pkg::ADDR_W-1:0]   mem_dst [TABLE_ENTRIES];
    logic [apfc_pkg::COUNT_W-1:0]  mem_cnt [TABLE_ENTRIES];
    logic [apfc_pkg::ADDR_W-1:0]   r_rd_src;
    logic [apfc_pkg::ADDR_W-1:0]   r_rd_dst;
    logic [apfc_pkg::COUNT_W-1:0]  r_rd_cnt;

    logic                          rd_en;
    logic [IDX_W-1:0]              rd_addr;
    logic                          wr_pair_en;
    logic                          wr_cnt_en;
    logic [IDX_W-1:0]              wr_addr;
    logic [apfc_pkg::COUNT_W-1:0]  wr_cnt;

    logic                          r_out_valid;
    apfc_pkg::t_result             r_out;
    apfc_pkg::t_result             n_out;
    logic                          load_out;
    logic                          out_free;

    logic                          match;
    logic                          last;
    logic [apfc_pkg::COUNT_W-1:0]  sat_cnt;

    assign out_free = !r_out_valid || o_result.ready;
    assign match    = (r_rd_src == r_task.src_addr) && (r_rd_dst == r_task.dst_addr);
    assign last     = ((CNT_W'(r_cmp_addr) + CNT_W'(1)) == r_fill);
    assign sat_cnt  = (r_rd_cnt == '1) ? r_rd_cnt : r_rd_cnt + apfc_pkg::COUNT_W'(1);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            apfc_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_task.op == apfc_pkg::OP_READ) begin
                        n_state = apfc_pkg::S_READ;
                    end else if (r_fill == '0) begin
                        n_state = apfc_pkg::S_FINISH;
                    end else begin
                        n_state = apfc_pkg::S_SCAN;
                    end
                end
            end
            apfc_pkg::S_SCAN: begin
                if (match || last) begin
                    n_state = apfc_pkg::S_FINISH;
                end
            end
            apfc_pkg::S_READ: begin
                n_state = apfc_pkg::S_FINISH;
            end
            apfc_pkg::S_FINISH: begin
                if (out_free) begin
                    n_state = apfc_pkg::S_IDLE;
                end
            end
            default: n_state = apfc_pkg::S_IDLE;
        endcase
    end

    // Datapath controls and result assembly
    always_comb begin
        o_q_ready  = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = r_cmp_addr;
        n_task     = r_task;
        n_cmp_addr = r_cmp_addr;
        n_hit      = r_hit;
        n_rd_ok    = r_rd_ok;
        n_fill     = r_fill;
        wr_pair_en = 1'b0;
        wr_cnt_en  = 1'b0;
        wr_addr    = r_cmp_addr;
        wr_cnt     = sat_cnt;
        load_out   = 1'b0;
        n_out      = '0;
        unique case (r_state)
            apfc_pkg::S_IDLE: begin
                o_q_ready = 1'b1;
                if (i_q_valid) begin
                    n_task     = i_q_task;
                    n_hit      = 1'b0;
                    n_cmp_addr = '0;
                    if (i_q_task.op == apfc_pkg::OP_READ) begin
                        n_rd_ok = (CMP_W'(i_q_task.entry_index) < CMP_W'(r_fill));
                        rd_en   = n_rd_ok;
                        rd_addr = IDX_W'(i_q_task.entry_index);
                    end else begin
                        rd_en   = (r_fill != '0);
                        rd_addr = '0;
                    end
                end
            end
            apfc_pkg::S_SCAN: begin
                // Compare the slot read last cycle; read the next on a miss, if any
                if (match) begin
                    n_hit = 1'b1;
                end else if (!last) begin
                    rd_en      = 1'b1;
                    rd_addr    = r_cmp_addr + IDX_W'(1);
                    n_cmp_addr = r_cmp_addr + IDX_W'(1);
                end
            end
            apfc_pkg::S_READ: begin
            end
            apfc_pkg::S_FINISH: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (r_task.op == apfc_pkg::OP_READ) begin
                        n_out.slot = r_task.entry_index;
                        if (r_rd_ok) begin
                            n_out.entry_valid = 1'b1;
                            n_out.entry_src   = r_rd_src;
                            n_out.entry_dst   = r_rd_dst;
                            n_out.count       = r_rd_cnt;
                        end
                    end else if (r_hit) begin
                        wr_cnt_en   = 1'b1;
                        n_out.hit   = 1'b1;
                        n_out.slot  = apfc_pkg::SLOT_W'(r_cmp_addr);
                        n_out.count = sat_cnt;
                    end else if (r_fill < CNT_W'(TABLE_ENTRIES)) begin
                        // Append the new pair at the first free slot
                        wr_pair_en     = 1'b1;
                        wr_cnt_en      = 1'b1;
                        wr_addr        = r_fill[IDX_W-1:0];
                        wr_cnt         = apfc_pkg::COUNT_W'(1);
                        n_fill         = r_fill + CNT_W'(1);
                        n_out.inserted = 1'b1;
                        n_out.slot     = apfc_pkg::SLOT_W'(r_fill);
                        n_out.count    = apfc_pkg::COUNT_W'(1);
                    end else begin
                        n_out.dropped_full = 1'b1;
                    end
                    n_out.entries_used = apfc_pkg::USED_W'(n_fill);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= apfc_pkg::S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_task     <= n_task;
        r_cmp_addr <= n_cmp_addr;
        r_hit      <= n_hit;
        r_rd_ok    <= n_rd_ok;
        if (load_out) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_pair_en) begin
            mem_src[wr_addr] <= r_task.src_addr;
            mem_dst[wr_addr] <= r_task.dst_addr;
        end
        if (wr_cnt_en) begin
            mem_cnt[wr_addr] <= wr_cnt;
        end
        if (rd_en) begin
            r_rd_src <= mem_src[rd_addr];
            r_rd_dst <= mem_dst[rd_addr];
            r_rd_cnt <= mem_cnt[rd_addr];
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.hit          = r_out.hit;
    assign o_result.inserted     = r_out.inserted;
    assign o_result.dropped_full = r_out.dropped_full;
    assign o_result.slot         = r_out.slot;
    assign o_result.count        = r_out.count;
    assign o_result.entry_valid  = r_out.entry_valid;
    assign o_result.entry_src    = r_out.entry_src;
    assign o_result.entry_dst    = r_out.entry_dst;
    assign o_result.entries_used = r_out.entries_used;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(TABLE_ENTRIES))
        else $error("fill level beyond table size");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == apfc_pkg::S_SCAN) |-> (CNT_W'(r_cmp_addr) < r_fill))
        else $error("scan reached an unfilled slot");

    a_fill_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != apfc_pkg::S_FINISH) |=> $stable(r_fill))
        else $error("fill level changed outside the finish step");

    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot0({r_out.hit, r_out.inserted, r_out.dropped_full,
                                  r_out.entry_valid}))
        else $error("result carries more than one outcome");

endmodule

[sv/address_pair_flow_counter.sv]
// Address pair flow counter: counts packets per IPv4 source/destination pair.
//
// A record transaction scans the pair table one slot per clock through the
// single read port of the table memories, stopping at the first exact match
// (count incremented, saturating) or after the last filled slot (pair
// appended with count 1, or dropped and flagged when the table is full).
// A two-entry queue in front lets new transactions arrive while a lookup
// runs, and the result register lets the next lookup start while a result
// waits to be taken. Table contents are not cleared at reset; fill level,
// state and result valid flag are, so the block is ready once reset ends.
module address_pair_flow_counter #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    apfc_item_if.sink      i_item,
    apfc_result_if.source  o_result
);

    logic            q_valid;
    logic            q_ready;
    apfc_pkg::t_task q_task;

    apfc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .o_q_valid (q_valid),
        .o_q_task  (q_task),
        .i_q_ready (q_ready)
    );

    apfc_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_task  (q_task),
        .o_q_ready (q_ready),
        .o_result  (o_result)
    );

endmodule
